FILE: rtl/core/rsl_pkg.sv
`default_nettype none

package rsl_pkg;

  localparam int MAX_REPLICAS_DEF = 16;

  // Field widths of one input beat and one result beat.
  localparam int SIZE_W = 5;
  localparam int RND_W  = 31;
  localparam int ERR_W  = 8;
  localparam int LOAD_W = 32;
  localparam int OUT_W  = 4;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [ERR_W-1:0] ERROR_LIMIT_RST = 8'd3;

  // Dividend bits resolved per cycle in the start offset unit.
  localparam int MOD_STEP = 8;

  // Entries in the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    REG_BALANCE_MODE = 1'b0,
    REG_ERROR_LIMIT  = 1'b1
  } rsl_reg_t;

  // Classification that the front attaches to every beat it queues.
  typedef struct packed {
    logic first;
    logic last;
    logic cand;
  } rsl_cls_t;

  localparam int CLS_W = $bits(rsl_cls_t);

  typedef enum logic [1:0] {
    BK_FETCH,
    BK_MOD,
    BK_APPLY
  } rsl_bk_state_t;

endpackage

`default_nettype wire

FILE: rtl/core/replica_select_healthy_or_least_loaded.sv
`default_nettype none

// Replica selector. A list of up to MAX_REPLICAS replicas arrives one beat per
// replica; the first beat also carries the list size and a random value, and the
// beat with last_element set closes the list and yields one selected_index beat.
// In rotation mode (balance_mode 0) the result is the first healthy replica in
// circular order from random_value mod size; in balance mode (balance_mode 1) it
// is the first healthy replica with zero load, else the first with the least load.
// With no healthy replica the start offset is returned. A replica is healthy when
// its error count is below error_limit, which is sampled as each beat is taken.
// The front takes one beat per cycle while its two-entry queue has room. The back
// retires one beat per cycle while the queue holds beats and, for the last beat of
// a list, the output register has room. The first beat of each list waits while
// the back starts the start offset unit, which resolves the remainder over the
// 31-bit random value eight bits per cycle and hands it over; the back then applies
// it. The result of a list appears in the output register in the cycle after
// the last beat is retired. Configuration is written over the APB port at byte
// addresses 0 (balance_mode) and 4 (error_limit).
module replica_select_healthy_or_least_loaded
  import rsl_pkg::*;
#(
  parameter int MAX_REPLICAS = MAX_REPLICAS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [SIZE_W-1:0]     in_num_replicas,
  input  wire logic [RND_W-1:0]      in_random_value,
  input  wire logic [ERR_W-1:0]      in_error_count,
  input  wire logic [LOAD_W-1:0]     in_load_count,
  input  wire logic                  in_last_element,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [OUT_W-1:0]           out_selected_index,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0]      cfg_prdata,
  output logic                       cfg_pready
);

  localparam int POS_W = $clog2(MAX_REPLICAS + 1);
  localparam int IDX_W = (MAX_REPLICAS > 1) ? $clog2(MAX_REPLICAS) : 1;
  localparam int ENT_W = CLS_W + IDX_W + POS_W + RND_W + LOAD_W;

  logic             balance_mode_r;
  logic [ERR_W-1:0] error_limit_r;
  logic             cfg_wr;
  rsl_reg_t         cfg_reg;

  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_empty;
  logic [ENT_W-1:0] q_din;
  logic [ENT_W-1:0] q_dout;
  rsl_cls_t         head_cls;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_reg    = rsl_reg_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      balance_mode_r <= 1'b0;
      error_limit_r  <= ERROR_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_reg)
        REG_BALANCE_MODE: balance_mode_r <= cfg_pwdata[0];
        REG_ERROR_LIMIT:  error_limit_r  <= cfg_pwdata[ERR_W-1:0];
        default:          balance_mode_r <= balance_mode_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_reg)
      REG_BALANCE_MODE: cfg_prdata = {{(CFG_DATA_W-1){1'b0}}, balance_mode_r};
      REG_ERROR_LIMIT:  cfg_prdata = {{(CFG_DATA_W-ERR_W){1'b0}}, error_limit_r};
      default:          cfg_prdata = '0;
    endcase
  end

  rsl_front #(
    .MAX_REPLICAS(MAX_REPLICAS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_num_replicas(in_num_replicas),
    .in_random_value(in_random_value),
    .in_error_count (in_error_count),
    .in_load_count  (in_load_count),
    .in_last_element(in_last_element),
    .error_limit    (error_limit_r),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_din          (q_din)
  );

  rsl_queue #(
    .WIDTH(ENT_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .din  (q_din),
    .full (q_full),
    .pop  (q_pop),
    .dout (q_dout),
    .empty(q_empty)
  );

  rsl_back #(
    .MAX_REPLICAS(MAX_REPLICAS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_dout            (q_dout),
    .q_pop             (q_pop),
    .balance_mode      (balance_mode_r),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_selected_index(out_selected_index)
  );

  assign head_cls = rsl_cls_t'(q_dout[ENT_W-1 -: CLS_W]);

`ifndef NO_ASSERTIONS
  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("back retired a beat from an empty queue");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && head_cls.last) |=> out_valid)
    else $error("closing beat retired without a result");

  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(q_pop && head_cls.last))
    else $error("result raised without a closing beat");

  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (MAX_REPLICAS < 16)) |-> (int'(out_selected_index) < MAX_REPLICAS))
    else $error("selected index beyond the largest list");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/rsl_front.sv
`default_nettype none

module rsl_front
  import rsl_pkg::*;
#(
  parameter int MAX_REPLICAS = MAX_REPLICAS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [SIZE_W-1:0]       in_num_replicas,
  input  wire logic [RND_W-1:0]        in_random_value,
  input  wire logic [ERR_W-1:0]        in_error_count,
  input  wire logic [LOAD_W-1:0]       in_load_count,
  input  wire logic                    in_last_element,
  input  wire logic [ERR_W-1:0]        error_limit,
  input  wire logic                    q_full,
  output logic                         q_push,
  output logic [CLS_W+((MAX_REPLICAS > 1) ? $clog2(MAX_REPLICAS) : 1)
                +$clog2(MAX_REPLICAS+1)+RND_W+LOAD_W-1:0] q_din
);

  localparam int POS_W = $clog2(MAX_REPLICAS + 1);
  localparam int IDX_W = (MAX_REPLICAS > 1) ? $clog2(MAX_REPLICAS) : 1;
  localparam int CMP_W = (POS_W > SIZE_W) ? POS_W : SIZE_W;
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_REPLICAS);
  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_REPLICAS);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] size_r, size_nxt;
  logic [POS_W-1:0] size_first;
  logic [POS_W-1:0] size_cur;
  logic [CMP_W-1:0] lsize_ext;
  logic             first;
  logic             accept;
  rsl_cls_t         cls;

  assign lsize_ext = CMP_W'(in_num_replicas);

  // A size of zero counts as one, and sizes above the maximum are clamped.
  always_comb begin
    if (lsize_ext == '0) begin
      size_first = POS_W'(1);
    end else if (lsize_ext > MAX_CMP) begin
      size_first = MAX_POS;
    end else begin
      size_first = lsize_ext[POS_W-1:0];
    end
  end

  assign first    = (pos_r == '0);
  assign size_cur = first ? size_first : size_r;
  assign accept   = in_valid && !q_full;
  assign in_stall = q_full;
  assign q_push   = accept;

  assign cls.first = first;
  assign cls.last  = in_last_element;
  assign cls.cand  = (pos_r < size_cur) && (in_error_count < error_limit);

  assign q_din = {cls, pos_r[IDX_W-1:0], size_cur, in_random_value, in_load_count};

  always_comb begin
    pos_nxt  = pos_r;
    size_nxt = size_r;
    if (accept) begin
      size_nxt = size_cur;
      if (in_last_element) begin
        pos_nxt = '0;
      end else if (pos_r < MAX_POS) begin
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    size_r <= size_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/core/rsl_queue.sv
`default_nettype none

module rsl_queue
  import rsl_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      dout,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/rsl_mod.sv
`default_nettype none

module rsl_mod
  import rsl_pkg::*;
#(
  parameter int MAX_REPLICAS = MAX_REPLICAS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [RND_W-1:0]              dividend,
  input  wire logic [$clog2(MAX_REPLICAS+1)-1:0] divisor,
  output logic                               done,
  output logic [((MAX_REPLICAS > 1) ? $clog2(MAX_REPLICAS) : 1)-1:0] rem
);

  localparam int POS_W   = $clog2(MAX_REPLICAS + 1);
  localparam int IDX_W   = (MAX_REPLICAS > 1) ? $clog2(MAX_REPLICAS) : 1;
  localparam int MOD_CYC = (RND_W + MOD_STEP - 1) / MOD_STEP;
  localparam int PAD_W   = MOD_CYC * MOD_STEP;
  localparam int CNT_W   = $clog2(MOD_CYC + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [PAD_W-1:0] shf_r;
  logic [POS_W:0]   rem_r;
  logic [POS_W-1:0] div_r;
  logic [POS_W:0]   rem_nxt;

  // Restoring division, MOD_STEP dividend bits per cycle, most significant first.
  always_comb begin
    rem_nxt = rem_r;
    for (int i = 0; i < MOD_STEP; i++) begin
      rem_nxt = {rem_nxt[POS_W-1:0], shf_r[PAD_W-1-i]};
      if (rem_nxt >= {1'b0, div_r}) begin
        rem_nxt = rem_nxt - {1'b0, div_r};
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(MOD_CYC);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shf_r <= PAD_W'(dividend);
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      shf_r <= shf_r << MOD_STEP;
      rem_r <= rem_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/rsl_back.sv
`default_nettype none

module rsl_back
  import rsl_pkg::*;
#(
  parameter int MAX_REPLICAS = MAX_REPLICAS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_empty,
  input  wire logic [CLS_W+((MAX_REPLICAS > 1) ? $clog2(MAX_REPLICAS) : 1)
                     +$clog2(MAX_REPLICAS+1)+RND_W+LOAD_W-1:0] q_dout,
  output logic                     q_pop,
  input  wire logic                balance_mode,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [OUT_W-1:0]         out_selected_index
);

  localparam int POS_W = $clog2(MAX_REPLICAS + 1);
  localparam int IDX_W = (MAX_REPLICAS > 1) ? $clog2(MAX_REPLICAS) : 1;
  localparam int ENT_W = CLS_W + IDX_W + POS_W + RND_W + LOAD_W;

  rsl_cls_t          cls;
  logic [IDX_W-1:0]  idx;
  logic [POS_W-1:0]  size;
  logic [RND_W-1:0]  rnd;
  logic [LOAD_W-1:0] load;

  assign cls  = rsl_cls_t'(q_dout[ENT_W-1 -: CLS_W]);
  assign idx  = q_dout[LOAD_W+RND_W+POS_W +: IDX_W];
  assign size = q_dout[LOAD_W+RND_W +: POS_W];
  assign rnd  = q_dout[LOAD_W +: RND_W];
  assign load = q_dout[LOAD_W-1:0];

  rsl_bk_state_t state_r, state_nxt;

  logic             mod_start;
  logic             mod_done;
  logic [IDX_W-1:0] mod_rem;
  logic             can_take;

  logic [IDX_W-1:0]  off_r;
  logic              fh_v_r, fh_v_nxt;
  logic [IDX_W-1:0]  fh_r, fh_nxt;
  logic              fhs_v_r, fhs_v_nxt;
  logic [IDX_W-1:0]  fhs_r, fhs_nxt;
  logic              bv_r, bv_nxt;
  logic              zero_r, zero_nxt;
  logic [IDX_W-1:0]  best_r, best_nxt;
  logic [LOAD_W-1:0] bcnt_r, bcnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]  sel;
  logic [OUT_W-1:0]  out_idx_r;
  logic [OUT_W+IDX_W-1:0] sel_ext;

  rsl_mod #(
    .MAX_REPLICAS(MAX_REPLICAS)
  ) u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mod_start),
    .dividend(rnd),
    .divisor (size),
    .done    (mod_done),
    .rem     (mod_rem)
  );

  // The last beat of a list needs room in the output register.
  assign can_take = !cls.last || !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_FETCH: begin
        if (!q_empty && cls.first) begin
          state_nxt = BK_MOD;
        end
      end
      BK_MOD: begin
        if (mod_done) begin
          state_nxt = BK_APPLY;
        end
      end
      BK_APPLY: begin
        if (can_take) begin
          state_nxt = BK_FETCH;
        end
      end
      default: state_nxt = BK_FETCH;
    endcase
  end

  always_comb begin
    mod_start = 1'b0;
    q_pop     = 1'b0;
    unique case (state_r)
      BK_FETCH: begin
        mod_start = !q_empty && cls.first;
        q_pop     = !q_empty && !cls.first && can_take;
      end
      BK_MOD: begin
        q_pop = 1'b0;
      end
      BK_APPLY: begin
        q_pop = can_take;
      end
      default: q_pop = 1'b0;
    endcase
  end

  always_comb begin
    fh_v_nxt      = fh_v_r;
    fh_nxt        = fh_r;
    fhs_v_nxt     = fhs_v_r;
    fhs_nxt       = fhs_r;
    bv_nxt        = bv_r;
    zero_nxt      = zero_r;
    best_nxt      = best_r;
    bcnt_nxt      = bcnt_r;
    sel           = off_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (q_pop && cls.cand) begin
      if (!fh_v_r) begin
        fh_v_nxt = 1'b1;
        fh_nxt   = idx;
      end
      if (!fhs_v_r && (idx >= off_r)) begin
        fhs_v_nxt = 1'b1;
        fhs_nxt   = idx;
      end
      // Once a replica with no load is seen, nothing can beat it.
      if (!zero_r) begin
        if (load == '0) begin
          best_nxt = idx;
          bcnt_nxt = '0;
          bv_nxt   = 1'b1;
          zero_nxt = 1'b1;
        end else if (!bv_r || (load < bcnt_r)) begin
          best_nxt = idx;
          bcnt_nxt = load;
          bv_nxt   = 1'b1;
        end
      end
    end
    if (balance_mode) begin
      sel = bv_nxt ? best_nxt : off_r;
    end else if (fhs_v_nxt) begin
      sel = fhs_nxt;
    end else if (fh_v_nxt) begin
      sel = fh_nxt;
    end
    if (q_pop && cls.last) begin
      out_valid_nxt = 1'b1;
      fh_v_nxt      = 1'b0;
      fhs_v_nxt     = 1'b0;
      bv_nxt        = 1'b0;
      zero_nxt      = 1'b0;
    end
  end

  assign sel_ext = {{OUT_W{1'b0}}, sel};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_FETCH;
      fh_v_r      <= 1'b0;
      fhs_v_r     <= 1'b0;
      bv_r        <= 1'b0;
      zero_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fh_v_r      <= fh_v_nxt;
      fhs_v_r     <= fhs_v_nxt;
      bv_r        <= bv_nxt;
      zero_r      <= zero_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fh_r   <= fh_nxt;
    fhs_r  <= fhs_nxt;
    best_r <= best_nxt;
    bcnt_r <= bcnt_nxt;
    if (mod_done) begin
      off_r <= mod_rem;
    end
    if (q_pop && cls.last) begin
      out_idx_r <= sel_ext[OUT_W-1:0];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_selected_index = out_idx_r;

endmodule

`default_nettype wire
